// File: hdl/sdwl_pkg.sv
// Package for the stamped dedup work list: sizes, request and status codes, types.
`timescale 1ns / 1ps
package sdwl_pkg;
    localparam int SLOT_BITS  = 8;
    localparam int KEY_BITS   = 16;
    localparam int STAMP_BITS = 32;
    localparam int EVENT_BITS = 2;
    localparam int CNT_BITS   = SLOT_BITS + 1;

    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [STAMP_BITS-1:0] stamp_t;
    typedef logic [EVENT_BITS-1:0] event_t;
    typedef logic [CNT_BITS-1:0]   count_t;

    localparam logic [2:0] REQ_PUSH   = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_POP_LAST = 3'd2;
    localparam logic [2:0] REQ_POP_MIN  = 3'd3;
    localparam logic [2:0] REQ_POP_MAX  = 3'd4;
    localparam logic [2:0] REQ_POP_FIRST = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_NOTQ  = 2'd2;
    localparam logic [1:0] ST_STALE = 2'd3;

    // Per-slot record held in the slot memory, flags included.
    typedef struct packed {
        logic   stamped;
        logic   queued;
        event_t events;
        stamp_t stamp;
        key_t   key;
        slot_t  nxt;
        slot_t  prv;
    } rec_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_TAKE, S_SCAN_RD, S_SCAN_CMP, S_EXEC,
        S_PRD, S_PWR, S_NRD, S_NWR, S_RESULT
    } state_t;
endpackage

// File: hdl/stamped_dedup_work_list_unit.sv
// Top level of the stamped dedup work list.
`timescale 1ns / 1ps
// Usage: raise start with a request while busy is low; the request transfer happens
// at the rising edge where both hold. Exactly one result transfer follows: done is
// high for one cycle with out_slot, out_events, status and entry_count valid, and the
// receiver cannot stall it. busy stays high from the accepted request through the
// result cycle, so one request is in flight at a time; the next one can be taken at
// the earliest in the cycle after the result.
// Every record goes through the one port of the slot memory. A push, a remove or a
// pop reads the target record and writes it back; a push that appends behind a tail
// or a remove or pop of a queued slot with neighbors then costs a read and a write for
// each neighbor link, the previous neighbor first. Pop first and pop last take the
// head or the tail; min and max pops walk the list one entry per cycle to find the
// target. An unknown request or a pop on an empty list goes straight to the result.
// Reset clears head, tail and count, then a clearing pass writes zero into every slot
// record (stamp valid, queued mark and event flags included) while busy is high.
// Stamps, keys and links are read only after they were written.
module stamped_dedup_work_list_unit
    import sdwl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] req_type,
    input  slot_t      slot_id,
    input  event_t     event_bits,
    input  stamp_t     now_stamp,
    input  key_t       order_key,
    output logic       done,
    output slot_t      out_slot,
    output event_t     out_events,
    output logic [1:0] status,
    output count_t     entry_count
);
    state_t state_reg, state_next;
    slot_t  head_reg, head_next, tail_reg, tail_next;
    count_t cnt_reg, cnt_next;
    // Address of the clearing pass after reset.
    slot_t  clr_reg, clr_next;

    logic [2:0] req_reg;
    slot_t  sid_reg, sid_next;
    event_t evb_reg;
    stamp_t now_reg;
    key_t   key_reg;

    // Record of the target slot, kept after its read. Its prv and nxt fields name
    // the neighbors whose links are patched afterwards.
    rec_t   cur_reg, cur_next;
    // The next neighbor still needs its prev link patched.
    logic   fixn_reg, fixn_next;
    // Scan state for min/max pops.
    slot_t  best_reg, best_next, walk_reg, walk_next;
    key_t   bkey_reg, bkey_next;
    count_t left_reg, left_next;

    slot_t  oslot_reg, oslot_next;
    event_t oev_reg, oev_next;
    logic [1:0] ost_reg, ost_next;

    logic   m_we;
    slot_t  m_addr;
    rec_t   m_wd, m_rd;

    sdwl_ram u_ram (.clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));

    logic is_pop;
    assign is_pop = (req_reg == REQ_POP_LAST) || (req_reg == REQ_POP_MIN)
                 || (req_reg == REQ_POP_MAX) || (req_reg == REQ_POP_FIRST);

    always_comb
    begin
        state_next = state_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next = cnt_reg;
        clr_next = clr_reg;
        sid_next = sid_reg;
        cur_next = cur_reg;
        fixn_next = fixn_reg;
        best_next = best_reg;
        walk_next = walk_reg;
        bkey_next = bkey_reg;
        left_next = left_reg;
        oslot_next = oslot_reg;
        oev_next = oev_reg;
        ost_next = ost_reg;
        m_we = 1'b0;
        m_addr = sid_reg;
        m_wd = cur_reg;
        case (state_reg)
            S_CLEAR:
            begin
                // One record cleared per cycle after reset.
                m_we = 1'b1;
                m_addr = clr_reg;
                m_wd = '0;
                clr_next = clr_reg + slot_t'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    sid_next = slot_id;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                // Choose the target slot, then read its record.
                oslot_next = '0;
                oev_next = '0;
                ost_next = ST_DONE;
                if (req_reg == REQ_PUSH || req_reg == REQ_REMOVE)
                begin
                    oslot_next = sid_reg;
                    state_next = S_EXEC;
                end
                else if (is_pop)
                begin
                    if (cnt_reg == '0)
                    begin
                        ost_next = ST_EMPTY;
                        state_next = S_RESULT;
                    end
                    else if (req_reg == REQ_POP_LAST)
                    begin
                        sid_next = tail_reg;
                        state_next = S_TAKE;
                    end
                    else if (req_reg == REQ_POP_FIRST)
                    begin
                        sid_next = head_reg;
                        state_next = S_TAKE;
                    end
                    else
                    begin
                        walk_next = head_reg;
                        best_next = head_reg;
                        left_next = cnt_reg;
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    state_next = S_RESULT;
                end
                m_addr = sid_reg;
            end
            S_TAKE:
            begin
                // Address sid_reg presented; read arrives next cycle.
                m_addr = sid_reg;
                oslot_next = sid_reg;
                state_next = S_EXEC;
            end
            S_SCAN_RD:
            begin
                m_addr = walk_reg;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                // m_rd holds the record of walk_reg; the entry nearest the head wins ties.
                if (left_reg == cnt_reg
                    || (req_reg == REQ_POP_MAX ? (m_rd.key > bkey_reg)
                                               : (m_rd.key < bkey_reg)))
                begin
                    best_next = walk_reg;
                    bkey_next = m_rd.key;
                end
                left_next = left_reg - count_t'(1);
                walk_next = m_rd.nxt;
                m_addr = m_rd.nxt;
                if (left_reg == count_t'(1))
                begin
                    sid_next = (left_reg == cnt_reg ||
                                (req_reg == REQ_POP_MAX ? (m_rd.key > bkey_reg)
                                                        : (m_rd.key < bkey_reg)))
                               ? walk_reg : best_reg;
                    state_next = S_TAKE;
                end
                else
                begin
                    state_next = S_SCAN_CMP;
                end
            end
            S_EXEC:
            begin
                cur_next = m_rd;
                fixn_next = 1'b0;
                state_next = S_RESULT;
                m_we = 1'b1;
                m_wd = m_rd;
                if (req_reg == REQ_PUSH)
                begin
                    m_wd.events = m_rd.events | evb_reg;
                    oev_next = m_rd.events | evb_reg;
                    m_wd.key = key_reg;
                    if (!m_rd.stamped || m_rd.stamp < now_reg)
                    begin
                        m_wd.stamp = now_reg;
                        m_wd.stamped = 1'b1;
                        if (!m_rd.queued)
                        begin
                            m_wd.queued = 1'b1;
                            tail_next = sid_reg;
                            cnt_next = cnt_reg + count_t'(1);
                            if (cnt_reg == '0)
                            begin
                                head_next = sid_reg;
                            end
                            else
                            begin
                                // The old tail gets its next link set to this slot.
                                m_wd.prv = tail_reg;
                                cur_next = m_wd;
                                cur_next.nxt = sid_reg;
                                state_next = S_PRD;
                            end
                        end
                    end
                    else
                    begin
                        ost_next = ST_STALE;
                    end
                end
                else
                begin
                    // Remove or pop: clear the stamp valid bit and flags, unlink if queued.
                    oev_next = m_rd.events;
                    m_wd.stamped = 1'b0;
                    m_wd.queued = 1'b0;
                    m_wd.events = '0;
                    if (!m_rd.queued)
                    begin
                        ost_next = ST_NOTQ;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - count_t'(1);
                        if (sid_reg == head_reg)
                        begin
                            head_next = m_rd.nxt;
                        end
                        if (sid_reg == tail_reg)
                        begin
                            tail_next = m_rd.prv;
                        end
                        fixn_next = (sid_reg != tail_reg);
                        if (sid_reg != head_reg)
                        begin
                            state_next = S_PRD;
                        end
                        else if (sid_reg != tail_reg)
                        begin
                            state_next = S_NRD;
                        end
                    end
                end
            end
            S_PRD:
            begin
                m_addr = cur_reg.prv;
                state_next = S_PWR;
            end
            S_PWR:
            begin
                // The previous neighbor now points past the slot, or to it on a push.
                m_we = 1'b1;
                m_addr = cur_reg.prv;
                m_wd = m_rd;
                m_wd.nxt = cur_reg.nxt;
                state_next = fixn_reg ? S_NRD : S_RESULT;
            end
            S_NRD:
            begin
                m_addr = cur_reg.nxt;
                state_next = S_NWR;
            end
            S_NWR:
            begin
                m_we = 1'b1;
                m_addr = cur_reg.nxt;
                m_wd = m_rd;
                m_wd.prv = cur_reg.prv;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg <= '0;
            clr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg <= cnt_next;
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            req_reg <= req_type;
            evb_reg <= event_bits;
            now_reg <= now_stamp;
            key_reg <= order_key;
        end
        sid_reg <= sid_next;
        cur_reg <= cur_next;
        fixn_reg <= fixn_next;
        best_reg <= best_next;
        walk_reg <= walk_next;
        bkey_reg <= bkey_next;
        left_reg <= left_next;
        oslot_reg <= oslot_next;
        oev_reg <= oev_next;
        ost_reg <= ost_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESULT);
    assign out_slot = oslot_reg;
    assign out_events = oev_reg;
    assign status = ost_reg;
    assign entry_count = cnt_reg;
endmodule

// File: hdl/sdwl_ram.sv
// Single-port synchronous slot memory with registered read.
`timescale 1ns / 1ps
module sdwl_ram
    import sdwl_pkg::*;
(
    input  logic  clk,
    input  logic  we,
    input  slot_t addr,
    input  rec_t  wdata,
    output rec_t  rdata
);
    rec_t mem [0:(1<<SLOT_BITS)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: hdl/sdwl_checker.sv
// Port-level checker for the stamped dedup work list, bound to the top level.
`timescale 1ns / 1ps
module sdwl_checker
    import sdwl_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] status,
    input count_t     entry_count
);
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result without busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted request not busy");
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("busy after result");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count <= count_t'(1 << SLOT_BITS)) else $error("count overflow");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> entry_count == '0) else $error("bad empty");
endmodule

bind stamped_dedup_work_list_unit sdwl_checker u_sdwl_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .entry_count(entry_count)
);

// File: test/tb_top.sv
// Self-checking testbench for the stamped dedup work list unit.
`timescale 1ns / 1ps
module tb_top;
    import sdwl_pkg::*;

    // Request codes that the block must ignore.
    localparam logic [2:0] REQ_BAD_LO = 3'd6;
    localparam logic [2:0] REQ_BAD_HI = 3'd7;
    localparam int NSLOTS = 1 << SLOT_BITS;
    // A min or max pop over a full list walks 256 entries at one cycle each, the
    // clearing pass after reset writes each of the 256 slot records once, so this
    // is ample.
    localparam int STALL_LIMIT = 5000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [2:0] req_type;
    slot_t      slot_id;
    event_t     event_bits;
    stamp_t     now_stamp;
    key_t       order_key;
    logic       done;
    slot_t      out_slot;
    event_t     out_events;
    logic [1:0] status;
    count_t     entry_count;

    stamped_dedup_work_list_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .slot_id(slot_id), .event_bits(event_bits),
        .now_stamp(now_stamp), .order_key(order_key), .done(done),
        .out_slot(out_slot), .out_events(out_events), .status(status),
        .entry_count(entry_count)
    );

    // One result transfer as the block should report it.
    typedef struct {
        slot_t      slot;
        event_t     ev;
        logic [1:0] st;
        count_t     cnt;
    } outcome_t;

    // Shadow copy of the work list: per-slot records, links, head, tail, count.
    stamp_t wl_stamp   [NSLOTS];
    logic   wl_stamped [NSLOTS];
    event_t wl_events  [NSLOTS];
    key_t   wl_key     [NSLOTS];
    logic   wl_queued  [NSLOTS];
    slot_t  wl_next    [NSLOTS];
    slot_t  wl_prev    [NSLOTS];
    slot_t  wl_head;
    slot_t  wl_tail;
    count_t wl_total;

    outcome_t pending_outcomes[$];
    int       fail_count;
    int       idle_cycles;
    stamp_t   stamp_clock;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < NSLOTS; i++)
        begin
            wl_stamped[i] = 1'b0;
            wl_events[i]  = '0;
            wl_queued[i]  = 1'b0;
        end
        wl_head  = '0;
        wl_tail  = '0;
        wl_total = '0;
    end

    // Add one prediction at the back of the list of outstanding results.
    function automatic void queue_outcome(outcome_t o);
        pending_outcomes = {pending_outcomes, o};
    endfunction

    // Append a slot at the tail of the shadow list.
    function automatic void append_slot(slot_t s);
        if (wl_total == 0)
            wl_head = s;
        else
        begin
            wl_next[wl_tail] = s;
            wl_prev[s] = wl_tail;
        end
        wl_tail = s;
        wl_queued[s] = 1'b1;
        wl_total++;
    endfunction

    // Unlink a queued slot, then clear its stamp valid bit and flags. Returns the old flags.
    function automatic event_t extract_slot(slot_t s);
        event_t held;
        held = wl_events[s];
        if (wl_queued[s])
        begin
            if (s == wl_head)
                wl_head = wl_next[s];
            else
                wl_next[wl_prev[s]] = wl_next[s];
            if (s == wl_tail)
                wl_tail = wl_prev[s];
            else
                wl_prev[wl_next[s]] = wl_prev[s];
            wl_queued[s] = 1'b0;
            wl_total--;
        end
        wl_stamped[s] = 1'b0;
        wl_events[s] = '0;
        return held;
    endfunction

    // Walk from head; strict compare so the entry nearest the head wins ties.
    function automatic slot_t find_extreme_key(logic want_max);
        slot_t best;
        slot_t cur;
        best = wl_head;
        cur = wl_head;
        for (int n = 1; n < wl_total; n++)
        begin
            cur = wl_next[cur];
            if (want_max ? (wl_key[cur] > wl_key[best]) : (wl_key[cur] < wl_key[best]))
                best = cur;
        end
        return best;
    endfunction

    // Apply one request to the shadow list and return the result it causes.
    function automatic outcome_t predict_request(logic [2:0] req, slot_t sid, event_t evb,
                                                 stamp_t now, key_t key);
        outcome_t r;
        slot_t    victim;
        r.slot = '0;
        r.ev = '0;
        r.st = ST_DONE;
        if (req == REQ_PUSH)
        begin
            r.slot = sid;
            wl_events[sid] = wl_events[sid] | evb;
            wl_key[sid] = key;
            r.ev = wl_events[sid];
            if (!wl_stamped[sid] || wl_stamp[sid] < now)
            begin
                wl_stamp[sid] = now;
                wl_stamped[sid] = 1'b1;
                // A slot that is already queued keeps its place.
                if (!wl_queued[sid])
                    append_slot(sid);
            end
            else
                r.st = ST_STALE;
        end
        else if (req == REQ_REMOVE)
        begin
            r.slot = sid;
            if (!wl_queued[sid])
                r.st = ST_NOTQ;
            r.ev = extract_slot(sid);
        end
        else if (req == REQ_POP_LAST || req == REQ_POP_MIN || req == REQ_POP_MAX ||
                 req == REQ_POP_FIRST)
        begin
            if (wl_total == 0)
                r.st = ST_EMPTY;
            else
            begin
                if (req == REQ_POP_LAST)
                    victim = wl_tail;
                else if (req == REQ_POP_FIRST)
                    victim = wl_head;
                else
                    victim = find_extreme_key(req == REQ_POP_MAX);
                r.slot = victim;
                r.ev = extract_slot(victim);
            end
        end
        r.cnt = wl_total;
        return r;
    endfunction

    // Send one request: raise start at a clock edge, hold it until the edge at
    // which busy was low, then drop it. The prediction is made at that edge.
    task automatic send_request(logic [2:0] req, slot_t sid, event_t evb, stamp_t now,
                                key_t key);
        @(posedge clk);
        start      <= 1'b1;
        req_type   <= req;
        slot_id    <= sid;
        event_bits <= evb;
        now_stamp  <= now;
        order_key  <= key;
        do
            @(posedge clk);
        while (busy);
        queue_outcome(predict_request(req, sid, evb, now, key));
        start <= 1'b0;
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic wait_until_drained();
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random gap between bursts of transfers; zero about a third of the time.
    task automatic sender_gap();
        if ($urandom_range(0, 2) != 0)
            repeat ($urandom_range(1, 15)) @(posedge clk);
    endtask

    // Extremes of every field, every request type and each special case.
    task automatic test_directed();
        for (int r = REQ_POP_LAST; r <= REQ_POP_FIRST; r++)
            send_request(3'(r), 8'h00, 2'd0, '0, '0);       // pop on an empty list
        send_request(REQ_REMOVE, 8'hFF, 2'd3, '1, '1);      // remove of an unqueued slot
        send_request(REQ_BAD_LO, 8'hFF, 2'd3, '1, '1);
        send_request(REQ_BAD_HI, 8'h00, 2'd0, '0, '0);
        send_request(REQ_PUSH, 8'h00, 2'd0, '0, '0);
        send_request(REQ_PUSH, 8'hFF, 2'd3, '1, '1);
        send_request(REQ_PUSH, 8'h00, 2'd1, '0, 16'h0005); // equal stamp: stale push
        send_request(REQ_PUSH, 8'h00, 2'd2, 32'd9, '0);    // newer stamp on a queued slot
        send_request(REQ_PUSH, 8'hFF, 2'd1, 32'd3, 16'h1234); // older stamp: stale
        send_request(REQ_PUSH, 8'h07, 2'd1, 32'd1, '0);    // ties slot 0 on the min key
        send_request(REQ_PUSH, 8'h80, 2'd2, 32'd1, '1);    // ties nothing, max is slot 128
        send_request(REQ_POP_MIN, 8'h00, 2'd0, '0, '0);
        send_request(REQ_POP_MAX, 8'h00, 2'd0, '0, '0);
        send_request(REQ_PUSH, 8'h01, 2'd3, 32'd5, 16'h8000);
        send_request(REQ_REMOVE, 8'h80, 2'd0, '0, '0);     // remove of the slot that the max pop took
        send_request(REQ_POP_LAST, 8'h00, 2'd0, '0, '0);
        send_request(REQ_POP_FIRST, 8'h00, 2'd0, '0, '0);
        send_request(REQ_POP_FIRST, 8'h00, 2'd0, '0, '0);
        wait_until_drained();
    endtask

    // Mixed traffic on a small slot pool so that duplicates and stale stamps are common.
    task automatic test_random_traffic(int n_items);
        int          sent;
        int          burst;
        int          pick;
        logic [2:0]  req;
        slot_t       sid;
        stamp_t      now;
        sent = 0;
        while (sent < n_items)
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < n_items; b++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    req = REQ_PUSH;
                else if (pick < 55)
                    req = REQ_REMOVE;
                else if (pick < 65)
                    req = REQ_POP_LAST;
                else if (pick < 75)
                    req = REQ_POP_MIN;
                else if (pick < 85)
                    req = REQ_POP_MAX;
                else if (pick < 95)
                    req = REQ_POP_FIRST;
                else
                    req = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
                sid = ($urandom_range(0, 3) == 0) ? slot_t'($urandom) :
                                                   slot_t'($urandom_range(0, 15));
                // Mostly a slowly rising clock; now and then any value at all.
                stamp_clock = stamp_clock + $urandom_range(0, 2);
                now = ($urandom_range(0, 9) == 0) ? stamp_t'($urandom) : stamp_clock;
                send_request(req, sid, event_t'($urandom), now, key_t'($urandom));
                sent++;
            end
            sender_gap();
            if ($urandom_range(0, 19) == 0)
                wait_until_drained();
        end
        wait_until_drained();
    endtask

    // Fill every slot, then drain with a mix of pops so full-length scans are hit.
    task automatic test_fill_and_drain();
        int pick;
        for (int s = 0; s < NSLOTS; s++)
        begin
            stamp_clock++;
            send_request(REQ_PUSH, slot_t'(s), event_t'($urandom), stamp_clock,
                         key_t'($urandom_range(0, 63)));
        end
        for (int s = 0; s <= NSLOTS; s++)
        begin
            pick = $urandom_range(0, 3);
            send_request((pick == 0) ? REQ_POP_MIN : (pick == 1) ? REQ_POP_MAX :
                         (pick == 2) ? REQ_POP_FIRST : REQ_POP_LAST,
                         slot_t'($urandom), event_t'($urandom), stamp_t'($urandom),
                         key_t'($urandom));
            if ($urandom_range(0, 7) == 0)
                sender_gap();
        end
        wait_until_drained();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = REQ_PUSH;
        slot_id     = '0;
        event_bits  = '0;
        now_stamp   = '0;
        order_key   = '0;
        fail_count  = 0;
        stamp_clock = 32'd100;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_traffic(516);
        test_fill_and_drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Each done cycle is one result transfer; compare it with the oldest prediction.
    always @(posedge clk)
    begin
        outcome_t exp_r;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result transfer with nothing expected: out_slot %0d", out_slot);
                fail_count++;
            end
            else
            begin
                exp_r = pending_outcomes.pop_front();
                if (out_slot !== exp_r.slot)
                begin
                    $error("out_slot expected %0d actual %0d", exp_r.slot, out_slot);
                    fail_count++;
                end
                if (out_events !== exp_r.ev)
                begin
                    $error("out_events expected %0d actual %0d", exp_r.ev, out_events);
                    fail_count++;
                end
                if (status !== exp_r.st)
                begin
                    $error("status expected %0d actual %0d", exp_r.st, status);
                    fail_count++;
                end
                if (entry_count !== exp_r.cnt)
                begin
                    $error("entry_count expected %0d actual %0d", exp_r.cnt, entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: the run ends if no transfer of either kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end
endmodule

// File: stamped_dedup_work_list_unit.f
hdl/sdwl_pkg.sv
hdl/sdwl_ram.sv
hdl/stamped_dedup_work_list_unit.sv
hdl/sdwl_checker.sv
test/tb_top.sv
